// ===== src/hrbf_pkg.sv =====
// hrbf_pkg: types, codes and the field-name text shared by the response body framer
// depends on nothing; imported by http_response_body_framer_unit and its testbench
package hrbf_pkg;

   // receive event codes carried on the request channel
   typedef enum logic [2:0] {
      ACT_BYTE    = 3'd0,
      ACT_POLL    = 3'd1,
      ACT_GONE    = 3'd2,
      ACT_FAIL    = 3'd3,
      ACT_RESTART = 3'd4
   } action_type;

   // framing phase, also the status reported with every result word
   typedef enum logic [2:0] {
      PH_HEADER     = 3'd0,
      PH_BODY       = 3'd1,
      PH_DONE       = 3'd2,
      PH_SHORT_BODY = 3'd3,
      PH_HDR_LONG   = 3'd4,
      PH_HDR_CLOSED = 3'd5,
      PH_TIMEOUT    = 3'd6,
      PH_RX_ERROR   = 3'd7
   } phase_type;

   // content-length parser progress
   typedef enum logic [1:0] {
      PS_SEARCH = 2'd0,
      PS_SPACES = 2'd1,
      PS_DIGITS = 2'd2,
      PS_DONE   = 2'd3
   } parse_type;

   // register indexes on the csr port
   localparam logic [1:0] CSR_HEADER_LIMIT = 2'd0;
   localparam logic [1:0] CSR_RETRY_LIMIT  = 2'd1;

   localparam logic [15:0] HEADER_LIMIT_RESET = 16'd8192;
   localparam logic [19:0] RETRY_LIMIT_RESET  = 20'd200000;

   localparam int          CL_OUT_WIDTH  = 32;
   localparam logic [3:0]  NAME_LEN      = 4'd15;
   localparam logic [15:0] HDR_COUNT_MAX = 16'hFFFF;
   localparam logic [19:0] POLL_MAX      = 20'hFFFFF;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_C     = 8'h43;

   // one result word
   typedef struct packed {
      logic [7:0]              body_byte;
      logic                    body_valid;
      logic                    header_done;
      logic                    length_known;
      logic [CL_OUT_WIDTH-1:0] body_length;
      phase_type               status;
   } rsp_type;

   // "Content-Length:" one character per position
   function automatic logic [7:0] name_char(input logic [3:0] pos);
      logic [7:0] c;
      unique case (pos)
         4'd0:    c = 8'h43; // C
         4'd1:    c = 8'h6F; // o
         4'd2:    c = 8'h6E; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6E; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2D; // -
         4'd8:    c = 8'h4C; // L
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6E; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         4'd14:   c = 8'h3A; // :
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== src/http_response_body_framer_unit.sv =====
// http_response_body_framer_unit: http/1.1 response header scan and body framing
// depends on hrbf_pkg (types, codes, field-name text)
//
// usage
//   req channel: one receive event per word (byte, empty poll, connection gone,
//   receive failure, restart) with its data byte. a word is taken at a rising
//   edge with req_valid high and req_stall low.
//   rsp channel: exactly one result word per request word, in order: the body
//   byte if any, header-done flag, parsed content length and the status.
//   csr channel: header_limit (index 0) and retry_limit (index 1); csr_ready
//   is always high, write only while the block is idle.
// timing
//   the framing state is updated at the accepting edge; the result word is
//   queued and shown on rsp_* once the words ahead of it have left. one word
//   is taken every cycle while req_stall is low. the step is a single shallow
//   pass: byte compares, a saturating multiply-by-ten-and-add and a few counters.
// stall
//   a two-word result queue sits on the rsp side; req_stall rises only when
//   both entries are full, so a single stalled result never blocks the input.
// reset
//   synchronous active-high reset returns to header phase, clears all counters
//   and the parser, empties the result queue and loads the default limits.
module http_response_body_framer_unit
   import hrbf_pkg::*;
#(
   parameter int LENGTH_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_action,
   input  logic [7:0]              req_data_byte,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_body_byte,
   output logic                    rsp_body_valid,
   output logic                    rsp_header_done,
   output logic                    rsp_length_known,
   output logic [CL_OUT_WIDTH-1:0] rsp_body_length,
   output logic [2:0]              rsp_status,
   // configuration channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [19:0]             csr_data
);

   localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

   // configuration registers
   logic [15:0] header_limit_ff;
   logic [19:0] retry_limit_ff;

   // framing state
   phase_type               phase_ff,       phase_in;
   logic [2:0]              blank_ff,       blank_in;
   logic [3:0]              name_match_ff,  name_match_in;
   parse_type               parse_ff,       parse_in;
   logic [LENGTH_WIDTH-1:0] length_ff,      length_in;
   logic                    has_digit_ff,   has_digit_in;
   logic [15:0]             hdr_count_ff,   hdr_count_in;
   logic [LENGTH_WIDTH-1:0] body_count_ff,  body_count_in;
   logic [19:0]             polls_ff,       polls_in;

   // result queue, slot0 is the head
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;

   rsp_type    result;
   logic       push;
   logic       pop;

   // step helpers
   logic                      is_digit;
   logic [3:0]                digit;
   logic [LENGTH_WIDTH+3:0]   scaled;
   logic                      active;
   logic                      blank_hit;
   logic [LENGTH_WIDTH+31:0]  length_wide;

   assign csr_ready = 1'b1;
   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;

   assign rsp_body_byte    = slot0_ff.body_byte;
   assign rsp_body_valid   = slot0_ff.body_valid;
   assign rsp_header_done  = slot0_ff.header_done;
   assign rsp_length_known = slot0_ff.length_known;
   assign rsp_body_length  = slot0_ff.body_length;
   assign rsp_status       = slot0_ff.status;

   assign is_digit = (req_data_byte >= CHAR_ZERO) && (req_data_byte <= CHAR_NINE);
   assign digit    = 4'(req_data_byte - CHAR_ZERO);
   // length * 10 + digit, four spare bits catch the overflow
   assign scaled   = ({4'b0, length_ff} << 3) + ({4'b0, length_ff} << 1)
                   + (LENGTH_WIDTH+4)'(digit);
   assign active   = (phase_ff == PH_HEADER) || (phase_ff == PH_BODY);

   // one event step
   always_comb begin
      phase_in      = phase_ff;
      blank_in      = blank_ff;
      name_match_in = name_match_ff;
      parse_in      = parse_ff;
      length_in     = length_ff;
      has_digit_in  = has_digit_ff;
      hdr_count_in  = hdr_count_ff;
      body_count_in = body_count_ff;
      polls_in      = polls_ff;
      blank_hit     = 1'b0;
      result.body_byte   = 8'd0;
      result.body_valid  = 1'b0;
      result.header_done = 1'b0;

      unique case (action_type'(req_action))
         ACT_RESTART: begin
            phase_in      = PH_HEADER;
            blank_in      = 3'd0;
            name_match_in = 4'd0;
            parse_in      = PS_SEARCH;
            length_in     = '0;
            has_digit_in  = 1'b0;
            hdr_count_in  = 16'd0;
            body_count_in = '0;
            polls_in      = 20'd0;
         end
         ACT_BYTE: begin
            if (active) begin
               polls_in = 20'd0;
               if (phase_ff == PH_HEADER) begin
                  // content-length field parser
                  unique case (parse_ff)
                     PS_SEARCH: begin
                        if (name_match_ff < NAME_LEN &&
                            req_data_byte == name_char(name_match_ff)) begin
                           name_match_in = name_match_ff + 4'd1;
                        end else begin
                           name_match_in = (req_data_byte == CHAR_C) ? 4'd1 : 4'd0;
                        end
                        if (name_match_in >= NAME_LEN) begin
                           parse_in = PS_SPACES;
                        end
                     end
                     PS_SPACES: begin
                        if (req_data_byte != CHAR_SPACE) begin
                           if (is_digit) begin
                              length_in    = LENGTH_WIDTH'(digit);
                              has_digit_in = 1'b1;
                              parse_in     = PS_DIGITS;
                           end else begin
                              parse_in = PS_DONE;
                           end
                        end
                     end
                     PS_DIGITS: begin
                        if (is_digit) begin
                           if (scaled[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'd0) begin
                              length_in = LEN_MAX;
                           end else begin
                              length_in = scaled[LENGTH_WIDTH-1:0];
                           end
                        end else begin
                           parse_in = PS_DONE;
                        end
                     end
                     PS_DONE: begin
                     end
                     default: begin
                     end
                  endcase

                  if (hdr_count_ff < HDR_COUNT_MAX) begin
                     hdr_count_in = hdr_count_ff + 16'd1;
                  end

                  // cr lf cr lf tracker
                  if (req_data_byte == CHAR_CR) begin
                     blank_in = (blank_ff == 3'd2) ? 3'd3 : 3'd1;
                  end else if (req_data_byte == CHAR_LF &&
                               (blank_ff == 3'd1 || blank_ff == 3'd3)) begin
                     blank_in = blank_ff + 3'd1;
                  end else begin
                     blank_in = 3'd0;
                  end
                  blank_hit = (blank_in == 3'd4);

                  if (blank_hit) begin
                     result.header_done = 1'b1;
                     if (parse_in == PS_SPACES || parse_in == PS_DIGITS) begin
                        parse_in = PS_DONE;
                     end
                     phase_in = (has_digit_in && length_in == '0) ? PH_DONE : PH_BODY;
                  end else if (hdr_count_in >= header_limit_ff) begin
                     phase_in = PH_HDR_LONG;
                  end
               end else begin
                  // body byte pass-through, excess bytes never get here
                  result.body_byte  = req_data_byte;
                  result.body_valid = 1'b1;
                  if (body_count_ff < LEN_MAX) begin
                     body_count_in = body_count_ff + LENGTH_WIDTH'(1);
                  end
                  if (has_digit_ff && body_count_in >= length_ff) begin
                     phase_in = PH_DONE;
                  end
               end
            end
         end
         ACT_POLL: begin
            if (active) begin
               if (polls_ff < POLL_MAX) begin
                  polls_in = polls_ff + 20'd1;
               end
               if (polls_in >= retry_limit_ff) begin
                  phase_in = PH_TIMEOUT;
               end
            end
         end
         ACT_GONE: begin
            if (active) begin
               if (phase_ff == PH_HEADER) begin
                  phase_in = PH_HDR_CLOSED;
               end else begin
                  phase_in = (has_digit_ff && body_count_ff < length_ff) ?
                             PH_SHORT_BODY : PH_DONE;
               end
            end
         end
         ACT_FAIL: begin
            if (active) begin
               phase_in = PH_RX_ERROR;
            end
         end
         default: begin
            // unused codes leave everything as it is
         end
      endcase

      length_wide         = {{CL_OUT_WIDTH{1'b0}}, length_in};
      result.length_known = has_digit_in;
      result.body_length  = has_digit_in ? length_wide[CL_OUT_WIDTH-1:0] : '0;
      result.status       = phase_in;
   end

   // result queue next state
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      unique case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot0_in = result;
            end else begin
               slot1_in = result;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_in = result;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = result;
            end
         end
         default: begin
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_limit_ff <= HEADER_LIMIT_RESET;
         retry_limit_ff  <= RETRY_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_HEADER_LIMIT) begin
            header_limit_ff <= csr_data[15:0];
         end else if (csr_index == CSR_RETRY_LIMIT) begin
            retry_limit_ff <= csr_data;
         end
      end
   end

   // framing state, updated once per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         blank_ff      <= 3'd0;
         name_match_ff <= 4'd0;
         parse_ff      <= PS_SEARCH;
         length_ff     <= '0;
         has_digit_ff  <= 1'b0;
         hdr_count_ff  <= 16'd0;
         body_count_ff <= '0;
         polls_ff      <= 20'd0;
      end else if (push) begin
         phase_ff      <= phase_in;
         blank_ff      <= blank_in;
         name_match_ff <= name_match_in;
         parse_ff      <= parse_in;
         length_ff     <= length_in;
         has_digit_ff  <= has_digit_in;
         hdr_count_ff  <= hdr_count_in;
         body_count_ff <= body_count_in;
         polls_ff      <= polls_in;
      end
   end

   // result queue: occupancy is control, slots are payload
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // a restart always lands back in a clean header phase
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (push && req_action == ACT_RESTART) |=>
         (phase_ff == PH_HEADER && blank_ff == 3'd0 && parse_ff == PS_SEARCH))
      else $error("restart did not clear the framing state");

   // body bytes leave only while the body phase is open
   a_body_only_in_body: assert property (@(posedge clock) disable iff (reset)
      (push && result.body_valid) |-> (phase_ff == PH_BODY))
      else $error("body byte produced outside the body phase");

   // a final status holds until a restart word
   a_final_holds: assert property (@(posedge clock) disable iff (reset)
      (!active && !(push && req_action == ACT_RESTART)) |=> $stable(phase_ff))
      else $error("final status left without a restart");

   // the header-done word moves the phase to body or done
   a_header_done_phase: assert property (@(posedge clock) disable iff (reset)
      (push && result.header_done) |=> (phase_ff == PH_BODY || phase_ff == PH_DONE))
      else $error("header end did not open the body");

endmodule

// ===== tb/sv/hrbf_response_checker.sv =====
// hrbf_response_checker: watches the req, rsp and csr channels of the response body framer,
// predicts one result word per accepted receive event and compares it field by field
// depends on hrbf_pkg (codes, phases, result word layout)
module hrbf_response_checker
   import hrbf_pkg::*;
#(
   parameter int LENGTH_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [2:0]              req_action,
   input  logic [7:0]              req_data_byte,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [7:0]              rsp_body_byte,
   input  logic                    rsp_body_valid,
   input  logic                    rsp_header_done,
   input  logic                    rsp_length_known,
   input  logic [CL_OUT_WIDTH-1:0] rsp_body_length,
   input  logic [2:0]              rsp_status,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [19:0]             csr_data,
   output int                      mismatches,
   output int                      outstanding
);

   localparam logic [LENGTH_WIDTH-1:0] LEN_MAX      = '1;
   localparam logic [8*15-1:0]         LENGTH_FIELD = "Content-Length:";

   // framer state as predicted
   phase_type               fr_phase;
   logic [2:0]              crlf_match;
   logic [3:0]              name_pos;
   parse_type               len_stage;
   logic [LENGTH_WIDTH-1:0] len_value;
   logic                    len_seen_digit;
   logic [15:0]             hdr_count;
   logic [LENGTH_WIDTH-1:0] body_count;
   logic [19:0]             poll_count;
   logic [15:0]             hdr_limit;
   logic [19:0]             poll_limit;

   rsp_type expected_words [$];
   int      words_seen;

   function automatic void clear_framer();
      fr_phase       = PH_HEADER;
      crlf_match     = '0;
      name_pos       = '0;
      len_stage      = PS_SEARCH;
      len_value      = '0;
      len_seen_digit = 1'b0;
      hdr_count      = '0;
      body_count     = '0;
      poll_count     = '0;
   endfunction

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   function automatic rsp_type step_framer(input logic [2:0] act, input logic [7:0] b);
      rsp_type                 w;
      logic                    digit;
      logic                    active;
      logic [LENGTH_WIDTH+3:0] wide;
      w      = '0;
      digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      active = (fr_phase == PH_HEADER) || (fr_phase == PH_BODY);
      if (act == ACT_RESTART) begin
         clear_framer();
      end else if (active) begin
         case (act)
            ACT_BYTE: begin
               poll_count = '0;
               if (fr_phase == PH_HEADER) begin
                  // content-length field scan
                  case (len_stage)
                     PS_SEARCH: begin
                        if (name_pos < NAME_LEN &&
                            b == LENGTH_FIELD[8*(14 - int'(name_pos)) +: 8])
                           name_pos = name_pos + 4'd1;
                        else if (b == CHAR_C)
                           name_pos = 4'd1;
                        else
                           name_pos = 4'd0;
                        if (name_pos >= NAME_LEN)
                           len_stage = PS_SPACES;
                     end
                     PS_SPACES: begin
                        if (b != CHAR_SPACE) begin
                           if (digit) begin
                              len_value      = LENGTH_WIDTH'(b - CHAR_ZERO);
                              len_seen_digit = 1'b1;
                              len_stage      = PS_DIGITS;
                           end else begin
                              len_stage = PS_DONE;
                           end
                        end
                     end
                     PS_DIGITS: begin
                        if (digit) begin
                           wide = {4'd0, len_value};
                           wide = wide * (LENGTH_WIDTH+4)'(10)
                                + (LENGTH_WIDTH+4)'(b - CHAR_ZERO);
                           if (wide[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'd0)
                              len_value = LEN_MAX;
                           else
                              len_value = wide[LENGTH_WIDTH-1:0];
                        end else begin
                           len_stage = PS_DONE;
                        end
                     end
                     default: ;
                  endcase
                  if (hdr_count < HDR_COUNT_MAX)
                     hdr_count = hdr_count + 16'd1;
                  // blank line tracking
                  if (b == CHAR_CR)
                     crlf_match = (crlf_match == 3'd2) ? 3'd3 : 3'd1;
                  else if (b == CHAR_LF && (crlf_match == 3'd1 || crlf_match == 3'd3))
                     crlf_match = crlf_match + 3'd1;
                  else
                     crlf_match = 3'd0;
                  if (crlf_match == 3'd4) begin
                     w.header_done = 1'b1;
                     if (len_stage == PS_SPACES || len_stage == PS_DIGITS)
                        len_stage = PS_DONE;
                     if (len_seen_digit && len_value == '0)
                        fr_phase = PH_DONE;
                     else
                        fr_phase = PH_BODY;
                  end else if (hdr_count >= hdr_limit) begin
                     fr_phase = PH_HDR_LONG;
                  end
               end else begin
                  w.body_byte  = b;
                  w.body_valid = 1'b1;
                  if (body_count < LEN_MAX)
                     body_count = body_count + 1'b1;
                  if (len_seen_digit && body_count >= len_value)
                     fr_phase = PH_DONE;
               end
            end
            ACT_POLL: begin
               if (poll_count < POLL_MAX)
                  poll_count = poll_count + 20'd1;
               if (poll_count >= poll_limit)
                  fr_phase = PH_TIMEOUT;
            end
            ACT_GONE: begin
               if (fr_phase == PH_HEADER)
                  fr_phase = PH_HDR_CLOSED;
               else if (len_seen_digit && body_count < len_value)
                  fr_phase = PH_SHORT_BODY;
               else
                  fr_phase = PH_DONE;
            end
            ACT_FAIL: fr_phase = PH_RX_ERROR;
            default: ;
         endcase
      end
      w.length_known = len_seen_digit;
      w.body_length  = len_seen_digit ? len_value : '0;
      w.status       = fr_phase;
      return w;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         clear_framer();
         hdr_limit  = HEADER_LIMIT_RESET;
         poll_limit = RETRY_LIMIT_RESET;
         expected_words.delete();
         words_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HEADER_LIMIT)
               hdr_limit = csr_data[15:0];
            else if (csr_index == CSR_RETRY_LIMIT)
               poll_limit = csr_data;
         end
         if (req_valid && !req_stall)
            expected_words.push_back(step_framer(req_action, req_data_byte));
         if (rsp_valid && !rsp_stall) begin
            words_seen++;
            if (expected_words.size() == 0) begin
               report($sformatf("word %0d arrived with nothing expected", words_seen));
            end else begin
               want = expected_words.pop_front();
               if (rsp_body_byte !== want.body_byte)
                  report($sformatf("word %0d body_byte: got %0h expected %0h",
                                   words_seen, rsp_body_byte, want.body_byte));
               if (rsp_body_valid !== want.body_valid)
                  report($sformatf("word %0d body_valid: got %0b expected %0b",
                                   words_seen, rsp_body_valid, want.body_valid));
               if (rsp_header_done !== want.header_done)
                  report($sformatf("word %0d header_done: got %0b expected %0b",
                                   words_seen, rsp_header_done, want.header_done));
               if (rsp_length_known !== want.length_known)
                  report($sformatf("word %0d length_known: got %0b expected %0b",
                                   words_seen, rsp_length_known, want.length_known));
               if (rsp_body_length !== want.body_length)
                  report($sformatf("word %0d body_length: got %0d expected %0d",
                                   words_seen, rsp_body_length, want.body_length));
               if (rsp_status !== want.status)
                  report($sformatf("word %0d status: got %0d expected %0d",
                                   words_seen, rsp_status, want.status));
            end
         end
      end
      outstanding = expected_words.size();
   end

endmodule

// ===== tb/sv/http_response_body_framer_unit_test.sv =====
// http_response_body_framer_unit_test: stimulus and verdict for the response body framer
// builds http response event streams, writes the limit registers and applies back-pressure;
// depends on hrbf_pkg, http_response_body_framer_unit and hrbf_response_checker
module http_response_body_framer_unit_test;
   import hrbf_pkg::*;

   localparam int         RUN_LIMIT       = 800000;  // time units
   localparam int         SETTLE_CYCLES   = 8;       // wait after the last result is back
   localparam int         HOLD_OFF_CYCLES = 300;
   localparam int         PHASE_WORDS     = 200;
   // action codes the block must ignore
   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [2:0] act;
      logic [7:0] data;
   } rx_event_type;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    req_valid     = 1'b0;
   logic [2:0]              req_action    = ACT_BYTE;
   logic [7:0]              req_data_byte = 8'h00;
   logic                    rsp_stall     = 1'b0;
   logic                    csr_valid     = 1'b0;
   logic [1:0]              csr_index     = CSR_HEADER_LIMIT;
   logic [19:0]             csr_data      = 20'd0;
   logic                    req_stall;
   logic                    rsp_valid;
   logic [7:0]              rsp_body_byte;
   logic                    rsp_body_valid;
   logic                    rsp_header_done;
   logic                    rsp_length_known;
   logic [CL_OUT_WIDTH-1:0] rsp_body_length;
   logic [2:0]              rsp_status;
   logic                    csr_ready;

   int mismatch_total;
   int words_pending;

   // idling controls, written by the stimulus process; hold_offs_done by the receiver
   int send_gap_pct     = 0;
   int rsp_stall_pct    = 0;
   int hold_offs_wanted = 0;
   int hold_offs_done   = 0;

   // receive events waiting to be offered on the req channel
   rx_event_type rx_script [$];

   http_response_body_framer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_body_byte    (rsp_body_byte),
      .rsp_body_valid   (rsp_body_valid),
      .rsp_header_done  (rsp_header_done),
      .rsp_length_known (rsp_length_known),
      .rsp_body_length  (rsp_body_length),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   hrbf_response_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_body_byte    (rsp_body_byte),
      .rsp_body_valid   (rsp_body_valid),
      .rsp_header_done  (rsp_header_done),
      .rsp_length_known (rsp_length_known),
      .rsp_body_length  (rsp_body_length),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatches       (mismatch_total),
      .outstanding      (words_pending)
   );

   always #1 clock = ~clock;

   // receiver: random stall at the current rate, or one long hold-off when asked.
   // the hold-off is counted here so the sender keeps offering words meanwhile and
   // the block's result queue fills up and pushes back on req
   initial begin
      forever begin
         @(posedge clock);
         if (hold_offs_done < hold_offs_wanted) begin
            hold_offs_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   function automatic void add_event(input logic [2:0] act, input logic [7:0] data);
      rx_event_type ev;
      ev.act  = act;
      ev.data = data;
      rx_script.push_back(ev);
   endfunction

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         add_event(ACT_BYTE, s[i]);
   endtask

   task automatic add_crlf();
      add_event(ACT_BYTE, CHAR_CR);
      add_event(ACT_BYTE, CHAR_LF);
   endtask

   // occasional run of empty polls, long enough now and then to hit a small retry limit
   task automatic maybe_polls();
      int k;
      int n;
      if ($urandom_range(0, 19) == 0) begin
         n = $urandom_range(1, 8);
         for (k = 0; k < n; k++)
            add_event(ACT_POLL, 8'($urandom));
      end
   endtask

   // one response: restart, a few header lines with or without a content-length
   // field, the blank line, then a body that ends on its length, runs past it,
   // stops short with the connection gone, or fails
   task automatic add_response();
      int lines;
      int field_at;
      int line;
      int k;
      int n;
      int len_val;
      int ending;
      bit len_bounded;
      add_event(ACT_RESTART, 8'($urandom));
      lines       = $urandom_range(1, 3);
      field_at    = $urandom_range(0, 3);   // past the last line means no field
      len_bounded = 1'b0;
      len_val     = 0;
      for (line = 0; line < lines; line++) begin
         maybe_polls();
         if (line == field_at) begin
            len_val = $urandom_range(0, 12);
            case ($urandom_range(0, 9))
               // saturates at the largest value, body then only ends on close
               6: add_text("Content-Length: 4294967296");
               // name without digits leaves the length unknown
               7: add_text("Content-Length: x9");
               // match is case-sensitive
               8: add_text($sformatf("content-length: %0d", len_val));
               // stray C before the name restarts the match
               9: begin
                  add_text($sformatf("CContent-Length:%0d", len_val));
                  len_bounded = 1'b1;
               end
               5: begin
                  add_text($sformatf("Content-Length: %03d", len_val));
                  len_bounded = 1'b1;
               end
               default: begin
                  add_text("Content-Length:");
                  n = $urandom_range(0, 2);
                  for (k = 0; k < n; k++)
                     add_event(ACT_BYTE, CHAR_SPACE);
                  add_text($sformatf("%0d", len_val));
                  if ($urandom_range(0, 3) == 0)
                     add_text(" ;x");
                  len_bounded = 1'b1;
               end
            endcase
         end else begin
            case ($urandom_range(0, 9))
               0: add_text("Content-Length: 2");   // ignored after the field, parsed if before it
               1: add_text("Content-Type: t");
               2: add_text("CCont");
               default: begin
                  n = $urandom_range(0, 6);
                  for (k = 0; k < n; k++)
                     if ($urandom_range(0, 9) == 0)
                        add_event(ACT_BYTE, 8'($urandom));
                     else
                        add_event(ACT_BYTE, 8'($urandom_range(32, 126)));
               end
            endcase
         end
         add_crlf();
      end
      add_crlf();
      ending = $urandom_range(0, 9);
      if (len_bounded && ending < 6)
         n = len_val + $urandom_range(0, 3);
      else if (len_bounded)
         n = $urandom_range(0, len_val);
      else
         n = $urandom_range(0, 12);
      for (k = 0; k < n; k++) begin
         maybe_polls();
         add_event(ACT_BYTE, 8'($urandom));
      end
      if (!len_bounded || ending >= 5)
         add_event((ending == 9) ? ACT_FAIL : ACT_GONE, 8'($urandom));
   endtask

   // offer every queued event; a word is taken at an edge with valid high and
   // stall low, and valid stays up across back-to-back words
   task automatic play_script();
      rx_event_type ev;
      while (rx_script.size() != 0) begin
         ev = rx_script.pop_front();
         while ($urandom_range(0, 99) < send_gap_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_action    <= ev.act;
         req_data_byte <= ev.data;
         @(posedge clock);
         while (req_stall)
            @(posedge clock);
      end
   endtask

   // mostly well-formed responses, the rest raw noise over every action code
   task automatic play_chunk(input int words);
      int k;
      int n;
      while (rx_script.size() < words) begin
         if ($urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++)
               add_event(3'($urandom_range(ACT_BYTE, ACT_SPARE_LAST)), 8'($urandom));
         end else begin
            add_response();
         end
      end
      play_script();
   endtask

   // sender goes quiet until every predicted word has come back, then a few
   // more cycles; outstanding is read on the falling edge to stay clear of the
   // checker's update
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [19:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // both registers in back-to-back writes, valid dropped once after the pair
   task automatic configure(input logic [15:0] hdr_max, input logic [19:0] poll_max);
      write_reg(CSR_HEADER_LIMIT, {4'd0, hdr_max});
      write_reg(CSR_RETRY_LIMIT, poll_max);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [15:0] hdr_max, input logic [19:0] poll_max,
                            input int gap_pct, input int stall_pct);
      drain();
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      configure(hdr_max, poll_max);
      play_chunk(PHASE_WORDS);
   endtask

   initial begin
      int k;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part: short header limit, timeout on the second poll
      configure(16'd24, 20'd2);
      add_event(ACT_RESTART, 8'h00);
      for (k = ACT_SPARE_FIRST; k <= ACT_SPARE_LAST; k++)
         add_event(3'(k), 8'hFF);                 // spare codes change nothing
      add_event(ACT_POLL, 8'hAA);
      add_event(ACT_POLL, 8'h55);                 // reaches the retry limit
      add_event(ACT_BYTE, 8'hFF);                 // dropped in a final status
      add_event(ACT_RESTART, 8'hFF);
      add_text("Content-Length:0");               // zero length ends on the blank line
      add_crlf();
      add_crlf();
      add_event(ACT_BYTE, 8'h80);                 // past the length, dropped
      add_event(ACT_RESTART, 8'h00);
      add_event(ACT_BYTE, 8'h00);                 // nul is an ordinary header byte
      add_event(ACT_GONE, 8'h00);                 // closed inside the header
      add_event(ACT_RESTART, 8'h00);
      add_crlf();
      add_crlf();                                 // no length: body until close
      add_event(ACT_BYTE, 8'hFF);
      add_event(ACT_FAIL, 8'h00);
      play_script();

      // random phases: extremes of both limits and every idling mix
      run_phase(16'hFFFF, 20'hFFFFF, 0, 0);
      run_phase(16'd4, 20'd1, 85, 0);
      run_phase(16'd64, 20'd5, 0, 85);
      run_phase(16'd200, 20'd6, 18, 18);
      run_phase(HEADER_LIMIT_RESET, RETRY_LIMIT_RESET, 0, 0);

      // long receiver hold-off with the sender still pushing
      hold_offs_wanted = hold_offs_wanted + 1;
      play_chunk(PHASE_WORDS / 3);
      // sender pauses until every result is back, then carries on
      drain();
      play_chunk(PHASE_WORDS / 3);
      drain();

      if (mismatch_total == 0)
         $display("http_response_body_framer_unit regression: pass");
      else
         $display("http_response_body_framer_unit regression: fail");
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("http_response_body_framer_unit regression: fail");
      $finish;
   end

endmodule
